// ----- rtl/grid_bilinear_interpolator_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef GRID_BILINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define GRID_BILINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/gbi_pkg.sv -----
package gbi_pkg;

    localparam int LON_POINTS_DEF = 73;
    localparam int LAT_POINTS_DEF = 13;

    localparam int CELL_BITS  = 8;
    localparam int CELL_UNITS = 256;

    localparam int ENTRY_INDEX_W = 10;
    localparam int SAMPLE_W      = 32;
    localparam int LAT_W         = 12;
    localparam int LON_W         = 15;
    localparam int RESULT_W      = 48;
    localparam int SCALE_W       = 32;
    localparam int WEIGHT_W      = 2 * CELL_BITS + 1;
    localparam int PRODUCT_W     = SAMPLE_W + WEIGHT_W;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // Byte address of output_scale
    localparam logic [PADDR_W-1:0] ADDR_OUTPUT_SCALE = '0;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd52151890;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

endpackage

// ----- rtl/gbi_if.sv -----
interface gbi_in_if;
    logic                                  valid;
    logic                                  ready;
    gbi_pkg::t_op                          operation;
    logic        [gbi_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic        [gbi_pkg::SAMPLE_W-1:0]      entry_value;
    logic signed [gbi_pkg::LAT_W-1:0]         latitude;
    logic        [gbi_pkg::LON_W-1:0]         longitude;

    modport source (output valid, operation, entry_index, entry_value, latitude, longitude,
                    input ready);
    modport sink (input valid, operation, entry_index, entry_value, latitude, longitude,
                  output ready);
    modport mon (input valid, ready, operation, entry_index, entry_value, latitude,
                 longitude);
endinterface

interface gbi_out_if;
    logic                           valid;
    logic                           ready;
    logic [gbi_pkg::RESULT_W-1:0]   interpolated_value;
    logic                           is_query_result;

    modport source (output valid, interpolated_value, is_query_result, input ready);
    modport sink (input valid, interpolated_value, is_query_result, output ready);
    modport mon (input valid, ready, interpolated_value, is_query_result);
endinterface

// ----- rtl/gbi_ram.sv -----
module gbi_ram #(
    parameter int WIDTH = gbi_pkg::SAMPLE_W,
    parameter int DEPTH = (gbi_pkg::LON_POINTS_DEF * gbi_pkg::LAT_POINTS_DEF + 1) / 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ----- rtl/grid_bilinear_interpolator_unit.sv -----
// An accepted input beat passes the bank read, product, pair-sum, final-sum and scale registers to its result beat.
// Throughput: one beat per cycle unless the output stalls; the four corner words come from
// two banks split on address parity, each bank read at two addresses in the accept cycle.
// Reset (i_rst_n low, synchronous) clears every stage valid and sets output_scale to
// 10000/(4 pi) in Q16; the grid banks keep their contents and hold nothing until loaded.
module grid_bilinear_interpolator_unit #(
    parameter int LON_POINTS = gbi_pkg::LON_POINTS_DEF,
    parameter int LAT_POINTS = gbi_pkg::LAT_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gbi_in_if.sink                        i_in,
    gbi_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbi_pkg::PADDR_W-1:0]   paddr,
    input  logic [gbi_pkg::PDATA_W-1:0]   pwdata,
    output logic [gbi_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // Grid geometry
    localparam int GRID_WORDS = LON_POINTS * LAT_POINTS;
    localparam int GRID_AW    = $clog2(GRID_WORDS);
    localparam int AXW        = GRID_AW + 1;
    localparam int BANK_DEPTH = (GRID_WORDS + 1) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int CELL_W     = $clog2((LON_POINTS > LAT_POINTS) ? LON_POINTS : LAT_POINTS);
    localparam int U_W        = CELL_W + gbi_pkg::CELL_BITS;
    localparam int XW         = (GRID_AW > gbi_pkg::ENTRY_INDEX_W) ?
                                GRID_AW : gbi_pkg::ENTRY_INDEX_W;
    localparam int SW         = 16;

    // Coordinate limits in 5/256 degree units
    localparam int LAT_OFFSET = (LAT_POINTS - 1) * (gbi_pkg::CELL_UNITS / 2);
    localparam int LAT_MAX_U  = (LAT_POINTS - 1) * gbi_pkg::CELL_UNITS - 1;
    localparam int LON_MAX_U  = (LON_POINTS - 1) * gbi_pkg::CELL_UNITS - 1;

    localparam int FB  = gbi_pkg::CELL_BITS;
    localparam int WW  = gbi_pkg::WEIGHT_W;
    localparam int PW  = gbi_pkg::PRODUCT_W;
    localparam int DW  = gbi_pkg::SAMPLE_W;
    localparam int RW  = gbi_pkg::RESULT_W;
    localparam int SCW = gbi_pkg::SCALE_W;
    localparam int MW  = DW + SCW;

    // ------------------------------------------------------------------
    // Configuration port: a single register, output_scale at byte address 0.
    // ------------------------------------------------------------------
    logic [SCW-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= gbi_pkg::SCALE_RESET;
        end else if (psel && penable && pwrite && (paddr == gbi_pkg::ADDR_OUTPUT_SCALE)) begin
            r_scale <= pwdata[SCW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == gbi_pkg::ADDR_OUTPUT_SCALE) ? gbi_pkg::PDATA_W'(r_scale) : '0;

    // ------------------------------------------------------------------
    // Stage handshake: a stage takes a new beat when it is empty or its
    // contents move on in the same cycle, so bubbles close up and the
    // output register alone holds a stalled result.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic can1, can2, can3, can4, can5;
    logic accept;

    assign can5   = !r_v5 || o_out.ready;
    assign can4   = !r_v4 || can5;
    assign can3   = !r_v3 || can4;
    assign can2   = !r_v2 || can3;
    assign can1   = !r_v1 || can2;
    assign accept = i_in.valid && can1;

    assign i_in.ready = can1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (can1) r_v1 <= i_in.valid;
            if (can2) r_v2 <= r_v1;
            if (can3) r_v3 <= r_v2;
            if (can4) r_v4 <= r_v3;
            if (can5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: clamp the position, split into cell and fraction,
    // form the corner addresses and weights.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] lat_sum;
    logic [U_W-1:0]       ulat;
    logic [U_W-1:0]       ulon;
    logic [CELL_W-1:0]    ilat;
    logic [CELL_W-1:0]    ilon;
    logic [FB-1:0]        frac_a;
    logic [FB-1:0]        frac_b;
    logic [FB:0]          inv_a;
    logic [FB:0]          inv_b;
    logic [AXW-1:0]       addr_full;
    logic [GRID_AW-1:0]   addr_a;
    logic [GRID_AW-1:0]   addr_b;
    logic [WW-1:0]        n_w [4];

    always_comb begin
        lat_sum = SW'(i_in.latitude) + SW'(LAT_OFFSET);
        if (lat_sum < 0) begin
            ulat = '0;
        end else if (lat_sum > SW'(LAT_MAX_U)) begin
            ulat = U_W'(LAT_MAX_U);
        end else begin
            ulat = lat_sum[U_W-1:0];
        end
        if (SW'(i_in.longitude) > SW'(LON_MAX_U)) begin
            ulon = U_W'(LON_MAX_U);
        end else begin
            ulon = i_in.longitude[U_W-1:0];
        end
    end

    assign ilat   = ulat[U_W-1:FB];
    assign ilon   = ulon[U_W-1:FB];
    assign frac_a = ulat[FB-1:0];
    assign frac_b = ulon[FB-1:0];
    assign inv_a  = (FB+1)'(gbi_pkg::CELL_UNITS) - {1'b0, frac_a};
    assign inv_b  = (FB+1)'(gbi_pkg::CELL_UNITS) - {1'b0, frac_b};

    // Corner order: (lon, lat), (lon, lat+1), (lon+1, lat), (lon+1, lat+1)
    assign n_w[0] = WW'(inv_a)  * WW'(inv_b);
    assign n_w[1] = WW'(frac_a) * WW'(inv_b);
    assign n_w[2] = WW'(inv_a)  * WW'(frac_b);
    assign n_w[3] = WW'(frac_a) * WW'(frac_b);

    // Address A is (lon, lat); A+1 is the next latitude, B = A + LAT_POINTS
    // the next longitude. Each pair straddles both parity banks.
    assign addr_full = AXW'(ilon) * AXW'(LAT_POINTS) + AXW'(ilat);
    assign addr_a    = addr_full[GRID_AW-1:0];
    assign addr_b    = addr_a + GRID_AW'(LAT_POINTS);

    logic [BANK_AW-1:0] even_ra;
    logic [BANK_AW-1:0] even_rb;
    assign even_ra = addr_a[BANK_AW:1] + BANK_AW'(addr_a[0]);
    assign even_rb = addr_b[BANK_AW:1] + BANK_AW'(addr_b[0]);

    // Load path: loads beyond the grid are acknowledged but dropped.
    logic [XW-1:0] load_idx;
    logic          load_ok;
    logic [1:0]    bank_we;

    assign load_idx   = XW'(i_in.entry_index);
    assign load_ok    = accept && (i_in.operation == gbi_pkg::OP_LOAD) &&
                        (load_idx < XW'(GRID_WORDS));
    assign bank_we[0] = load_ok && !load_idx[0];
    assign bank_we[1] = load_ok && load_idx[0];

    // Reads and writes both happen at the accept edge and each beat is either
    // a load or a query, so a query always sees every earlier load.
    logic [DW-1:0] even_d0, even_d1, odd_d0, odd_d1;

    gbi_ram #(
        .WIDTH (DW),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .i_clk    (i_clk),
        .i_we     (bank_we[0]),
        .i_waddr  (load_idx[BANK_AW:1]),
        .i_wdata  (i_in.entry_value),
        .i_re     (accept),
        .i_raddr0 (even_ra),
        .i_raddr1 (even_rb),
        .o_rdata0 (even_d0),
        .o_rdata1 (even_d1)
    );

    gbi_ram #(
        .WIDTH (DW),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .i_clk    (i_clk),
        .i_we     (bank_we[1]),
        .i_waddr  (load_idx[BANK_AW:1]),
        .i_wdata  (i_in.entry_value),
        .i_re     (accept),
        .i_raddr0 (addr_a[BANK_AW:1]),
        .i_raddr1 (addr_b[BANK_AW:1]),
        .o_rdata0 (odd_d0),
        .o_rdata1 (odd_d1)
    );

    // ------------------------------------------------------------------
    // Stage 1: bank data arrives; steer words back into corner order.
    // ------------------------------------------------------------------
    gbi_pkg::t_op r_op1;
    logic         r_pa1;
    logic         r_pb1;
    logic [WW-1:0] r_w1 [4];
    logic [DW-1:0] word [4];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op1 <= i_in.operation;
            r_pa1 <= addr_a[0];
            r_pb1 <= addr_b[0];
            for (int k = 0; k < 4; k++) begin
                r_w1[k] <= n_w[k];
            end
        end
    end

    assign word[0] = r_pa1 ? odd_d0  : even_d0;
    assign word[1] = r_pa1 ? even_d0 : odd_d0;
    assign word[2] = r_pb1 ? odd_d1  : even_d1;
    assign word[3] = r_pb1 ? even_d1 : odd_d1;

    // ------------------------------------------------------------------
    // Stage 2: corner products.
    // ------------------------------------------------------------------
    gbi_pkg::t_op r_op2;
    logic [PW-1:0] r_p2 [4];

    always_ff @(posedge i_clk) begin
        if (can2 && r_v1) begin
            r_op2 <= r_op1;
            for (int k = 0; k < 4; k++) begin
                r_p2[k] <= PW'(word[k]) * PW'(r_w1[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pair sums.
    // ------------------------------------------------------------------
    gbi_pkg::t_op r_op3;
    logic [PW:0]  r_s3 [2];

    always_ff @(posedge i_clk) begin
        if (can3 && r_v2) begin
            r_op3   <= r_op2;
            r_s3[0] <= (PW+1)'(r_p2[0]) + (PW+1)'(r_p2[1]);
            r_s3[1] <= (PW+1)'(r_p2[2]) + (PW+1)'(r_p2[3]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final sum, drop the 16 weight fraction bits. The weights
    // total 65536, so the interpolated word fits the sample width.
    // ------------------------------------------------------------------
    gbi_pkg::t_op  r_op4;
    logic [DW-1:0] r_v4_val;
    logic [PW+1:0] n_sum;

    assign n_sum = (PW+2)'(r_s3[0]) + (PW+2)'(r_s3[1]);

    always_ff @(posedge i_clk) begin
        if (can4 && r_v3) begin
            r_op4    <= r_op3;
            r_v4_val <= n_sum[2*FB+DW-1:2*FB];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: apply the Q16 scale into the output register. Loads
    // return zero.
    // ------------------------------------------------------------------
    logic [MW-1:0] n_scaled;
    logic [RW-1:0] r_out_val;
    logic          r_out_q;

    assign n_scaled = MW'(r_v4_val) * MW'(r_scale);

    always_ff @(posedge i_clk) begin
        if (can5 && r_v4) begin
            r_out_q   <= (r_op4 == gbi_pkg::OP_QUERY);
            r_out_val <= (r_op4 == gbi_pkg::OP_QUERY) ? n_scaled[RW+15:16] : '0;
        end
    end

    assign o_out.valid              = r_v5;
    assign o_out.interpolated_value = r_out_val;
    assign o_out.is_query_result    = r_out_q;

endmodule

// ----- rtl/gbi_checker.sv -----
`include "grid_bilinear_interpolator_unit_assert.svh"

module gbi_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [gbi_pkg::RESULT_W-1:0] i_value,
    input logic                         i_is_query
);

    // A stalled result beat keeps its place and contents.
    `GBI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready,
                     i_valid && $stable(i_value) && $stable(i_is_query))

    // A load acknowledgement carries a zero value.
    `GBI_ASSERT_SAME(a_load_zero, i_clk, i_rst_n, i_valid && !i_is_query, i_value == '0)

    // Reset empties the output register.
    `GBI_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !i_valid)

endmodule

bind grid_bilinear_interpolator_unit gbi_checker u_gbi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_out.valid),
    .i_ready    (o_out.ready),
    .i_value    (o_out.interpolated_value),
    .i_is_query (o_out.is_query_result)
);
